FILE: rtl/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg: shared types and constants of the PI current loop
// Field types, stage words passed between the pipeline stages, mode and
// drive-action codes, register indexes and loop limits.
// ----------------------------------------------------------------------------
package pcl_pkg;

	// Operating modes carried by each input word.
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_PWM   = 2'd1,
		MODE_TUNE  = 2'd2,
		MODE_TRACK = 2'd3
	} mode_t;

	// What the last stage does with the held drive.
	typedef enum logic [1:0] {
		ACT_ZERO   = 2'd0,
		ACT_MANUAL = 2'd1,
		ACT_LOOP   = 2'd2,
		ACT_HOLD   = 2'd3
	} act_t;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;

	// Loop constants.
	localparam logic signed [9:0]  INTEG_LIMIT        = 10'sd500;
	localparam logic signed [11:0] SQUARE_HIGH_MA     = 12'sd200;
	localparam logic [4:0]         SQUARE_HALF_PERIOD = 5'd19;
	localparam logic signed [7:0]  DRIVE_LIMIT        = 8'sd100;
	localparam logic [11:0]        DUTY_FULL          = 12'd4000;
	localparam logic [5:0]         DUTY_STEP          = 6'(DUTY_FULL / 12'd100);

	// Input word as received.
	typedef struct packed {
		mode_t              mode;
		logic signed [12:0] sensed_ma;
		logic signed [11:0] reference_ma;
		logic signed [7:0]  manual_percent;
		logic               loop_enable;
		logic               log_enable;
	} in_word_t;

	// Word after the error and integral update.
	typedef struct packed {
		act_t               act;
		logic signed [13:0] err;
		logic signed [9:0]  integral;
		logic signed [7:0]  manual;
		logic signed [11:0] reference_used;
		logic               record;
	} err_word_t;

	// Word after the two gain products.
	typedef struct packed {
		act_t               act;
		logic signed [29:0] prod_p;
		logic signed [25:0] prod_i;
		logic signed [7:0]  manual;
		logic signed [11:0] reference_used;
		logic               record;
	} mac_word_t;

	// Result word.
	typedef struct packed {
		logic [11:0]        duty_count;
		logic               direction;
		logic signed [7:0]  drive_percent;
		logic signed [11:0] reference_used;
		logic               record_valid;
	} result_t;

endpackage

FILE: rtl/pcl_err_stage.sv
// ----------------------------------------------------------------------------
// pcl_err_stage: error, integral and square-wave state
// Decodes the mode, forms the loop error, updates the clamped integral and
// the tune square reference, and registers the stage word.
// ----------------------------------------------------------------------------
module pcl_err_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pcl_pkg::in_word_t   in_s1,
	output pcl_pkg::err_word_t  word_s2
);
	import pcl_pkg::*;

	logic signed [9:0]  integral_q;
	logic [4:0]         tick_q;
	logic               square_q;

	logic signed [9:0]  integral_d;
	logic [4:0]         tick_d;
	logic               square_d;
	logic [4:0]         tick_inc;
	logic signed [11:0] ref_sel;
	logic signed [13:0] err_c;
	logic signed [14:0] sum_c;
	logic signed [9:0]  integ_clamped;
	logic signed [7:0]  manual_c;
	err_word_t          word_d;

	always_comb begin
		ref_sel = (in_s1.mode == MODE_TUNE) ? (square_q ? SQUARE_HIGH_MA : 12'sd0)
			: in_s1.reference_ma;
		err_c = $signed({{2{ref_sel[11]}}, ref_sel})
			- $signed({in_s1.sensed_ma[12], in_s1.sensed_ma});
		sum_c = $signed({{5{integral_q[9]}}, integral_q}) + $signed({err_c[13], err_c});
		if (sum_c > $signed({{5{INTEG_LIMIT[9]}}, INTEG_LIMIT})) begin
			integ_clamped = INTEG_LIMIT;
		end else if (sum_c < -$signed({{5{INTEG_LIMIT[9]}}, INTEG_LIMIT})) begin
			integ_clamped = -INTEG_LIMIT;
		end else begin
			integ_clamped = sum_c[9:0];
		end
		if (in_s1.manual_percent > DRIVE_LIMIT) begin
			manual_c = DRIVE_LIMIT;
		end else if (in_s1.manual_percent < -DRIVE_LIMIT) begin
			manual_c = -DRIVE_LIMIT;
		end else begin
			manual_c = in_s1.manual_percent;
		end
		tick_inc = tick_q + 5'd1;
	end

	always_comb begin
		integral_d            = integral_q;
		tick_d                = tick_q;
		square_d              = square_q;
		word_d.act            = ACT_HOLD;
		word_d.err            = err_c;
		word_d.integral       = integ_clamped;
		word_d.manual         = manual_c;
		word_d.reference_used = 12'sd0;
		word_d.record         = 1'b0;
		case (in_s1.mode)
			MODE_IDLE: begin
				integral_d = 10'sd0;
				word_d.act = ACT_ZERO;
			end
			MODE_PWM: begin
				word_d.act = ACT_MANUAL;
			end
			MODE_TUNE: begin
				if (in_s1.loop_enable) begin
					integral_d            = integ_clamped;
					word_d.act            = ACT_LOOP;
					word_d.reference_used = ref_sel;
					word_d.record         = in_s1.log_enable;
					// The square reference flips after each half period of running ticks.
					if (tick_inc >= SQUARE_HALF_PERIOD) begin
						tick_d   = 5'd0;
						square_d = ~square_q;
					end else begin
						tick_d = tick_inc;
					end
				end else begin
					integral_d = 10'sd0;
					tick_d     = 5'd0;
				end
			end
			MODE_TRACK: begin
				if (in_s1.loop_enable) begin
					integral_d            = integ_clamped;
					word_d.act            = ACT_LOOP;
					word_d.reference_used = ref_sel;
					word_d.record         = in_s1.log_enable;
				end else begin
					integral_d = 10'sd0;
				end
			end
			default: begin
				word_d.act = ACT_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= 10'sd0;
			tick_q     <= 5'd0;
			square_q   <= 1'b0;
		end else if (load) begin
			integral_q <= integral_d;
			tick_q     <= tick_d;
			square_q   <= square_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s2 <= word_d;
		end
	end

endmodule

FILE: rtl/pcl_mac_stage.sv
// ----------------------------------------------------------------------------
// pcl_mac_stage: gain products
// Multiplies the error by the proportional gain and the integral by the
// integral gain, one multiplier each, and registers both products.
// ----------------------------------------------------------------------------
module pcl_mac_stage (
	input  logic                clk,
	input  logic                load,
	input  logic signed [15:0]  prop_gain,
	input  logic signed [15:0]  integral_gain,
	input  pcl_pkg::err_word_t  word_s2,
	output pcl_pkg::mac_word_t  word_s3
);
	import pcl_pkg::*;

	mac_word_t word_d;

	always_comb begin
		word_d.act            = word_s2.act;
		word_d.prod_p         = 30'(prop_gain) * 30'(word_s2.err);
		word_d.prod_i         = 26'(integral_gain) * 26'(word_s2.integral);
		word_d.manual         = word_s2.manual;
		word_d.reference_used = word_s2.reference_used;
		word_d.record         = word_s2.record;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s3 <= word_d;
		end
	end

endmodule

FILE: rtl/pcl_drive_stage.sv
// ----------------------------------------------------------------------------
// pcl_drive_stage: drive saturation and duty conversion
// Sums the products, scales the Q23.8 sum toward zero, saturates it,
// updates the held drive and registers the result word.
// ----------------------------------------------------------------------------
module pcl_drive_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pcl_pkg::mac_word_t  word_s3,
	output pcl_pkg::result_t    result_q
);
	import pcl_pkg::*;

	logic signed [7:0]  held_q;
	logic signed [30:0] acc_c;
	logic signed [30:0] biased_c;
	logic signed [22:0] quo_c;
	logic signed [7:0]  loop_drive;
	logic signed [7:0]  held_d;
	logic [7:0]         abs_c;
	logic [6:0]         mag_c;
	result_t            result_d;

	always_comb begin
		acc_c = $signed({word_s3.prod_p[29], word_s3.prod_p})
			+ $signed({{5{word_s3.prod_i[25]}}, word_s3.prod_i});
		// Adding 255 to a negative sum makes the shift truncate toward zero.
		biased_c = acc_c[30] ? (acc_c + 31'sd255) : acc_c;
		quo_c    = biased_c[30:8];
		if (quo_c > $signed({{15{DRIVE_LIMIT[7]}}, DRIVE_LIMIT})) begin
			loop_drive = DRIVE_LIMIT;
		end else if (quo_c < -$signed({{15{DRIVE_LIMIT[7]}}, DRIVE_LIMIT})) begin
			loop_drive = -DRIVE_LIMIT;
		end else begin
			loop_drive = quo_c[7:0];
		end

		case (word_s3.act)
			ACT_ZERO:   held_d = 8'sd0;
			ACT_MANUAL: held_d = word_s3.manual;
			ACT_LOOP:   held_d = loop_drive;
			ACT_HOLD:   held_d = held_q;
			default:    held_d = held_q;
		endcase

		abs_c = held_d[7] ? 8'(-held_d) : held_d;
		mag_c = abs_c[6:0];

		result_d.duty_count     = {5'd0, mag_c} * {6'd0, DUTY_STEP};
		result_d.direction      = ~held_d[7];
		result_d.drive_percent  = held_d;
		result_d.reference_used = word_s3.reference_used;
		result_d.record_valid   = word_s3.record;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 8'sd0;
		end else if (load) begin
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

endmodule

FILE: rtl/pi_current_loop_pwm.sv
// ----------------------------------------------------------------------------
// pi_current_loop_pwm: PI motor-current loop with anti-windup and PWM output
// Top level: stream ports, gain registers, input register and pipeline
// valid tracking around the error, product and drive stages.
// ----------------------------------------------------------------------------
// The block takes one control tick word per clock cycle while the output
// is not held back and returns one result word per tick, in order. The
// result word passes four registers after the tick is accepted: input
// register, error and integral stage, gain product stage, drive and result
// register. Each stage holds its word only while the next one is full, so a
// stalled output still lets earlier stages fill. The integral and the square
// reference are updated in the error stage, which keeps the loop state exact
// for ticks that follow directly. Gains must be written through the
// configuration channel only while no tick is in flight; not enforced here.
module pi_current_loop_pwm (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode[1:0], sensed_ma[14:2], reference_ma[26:15], manual_percent[34:27],
	// loop_enable[35], log_enable[36], zero fill[39:37]
	input  logic [39:0] s_axis_tdata,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// duty_count[11:0], direction[12], drive_percent[20:13],
	// reference_used[32:21], record_valid[33], zero fill[39:34]
	output logic [39:0] m_axis_tdata
);
	import pcl_pkg::*;

	logic signed [15:0] prop_gain_q;
	logic signed [15:0] integral_gain_q;

	in_word_t  in_s1;
	err_word_t word_s2;
	mac_word_t word_s3;
	result_t   result_q;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic out_valid_q;
	logic go1;
	logic go2;
	logic go3;
	logic in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= 16'sd0;
			integral_gain_q <= 16'sd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROP_GAIN:     prop_gain_q     <= cfg_data;
				REG_INTEGRAL_GAIN: integral_gain_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Each stage moves forward when the next one is empty or moving too.
	assign go3           = v_s3 & (~out_valid_q | m_axis_tready);
	assign go2           = v_s2 & (~v_s3 | go3);
	assign go1           = v_s1 & (~v_s2 | go2);
	assign s_axis_tready = ~v_s1 | go1;
	assign in_take       = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1        <= in_take | (v_s1 & ~go1);
			v_s2        <= go1 | (v_s2 & ~go2);
			v_s3        <= go2 | (v_s3 & ~go3);
			out_valid_q <= go3 | (out_valid_q & ~m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			in_s1.mode           <= mode_t'(s_axis_tdata[1:0]);
			in_s1.sensed_ma      <= s_axis_tdata[14:2];
			in_s1.reference_ma   <= s_axis_tdata[26:15];
			in_s1.manual_percent <= s_axis_tdata[34:27];
			in_s1.loop_enable    <= s_axis_tdata[35];
			in_s1.log_enable     <= s_axis_tdata[36];
		end
	end

	pcl_err_stage u_err (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (go1),
		.in_s1   (in_s1),
		.word_s2 (word_s2)
	);

	pcl_mac_stage u_mac (
		.clk           (clk),
		.load          (go2),
		.prop_gain     (prop_gain_q),
		.integral_gain (integral_gain_q),
		.word_s2       (word_s2),
		.word_s3       (word_s3)
	);

	pcl_drive_stage u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go3),
		.word_s3  (word_s3),
		.result_q (result_q)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, result_q.record_valid, result_q.reference_used,
		result_q.drive_percent, result_q.direction, result_q.duty_count};

endmodule

FILE: dv/pi_current_loop_pwm_test.sv
// ----------------------------------------------------------------------------
// pi_current_loop_pwm_test: self-checking testbench of the PI current loop
// Drives control tick words through the input stream and compares each result
// word against a cycle-free model of the loop state. A directed table with
// hand-computed results runs first, then random ticks over several gain
// settings, with random idling on both streams and long output back-pressure.
// ----------------------------------------------------------------------------
module pi_current_loop_pwm_test;
	import pcl_pkg::*;

	localparam int INTEG_MAX       = 500;
	localparam int TUNE_HIGH_MA    = 200;
	localparam int TUNE_HALF_TICKS = 19;
	localparam int PCT_MAX         = 100;
	localparam int COUNTS_PER_PCT  = 40;
	localparam int STALL_LIMIT     = 2000;
	localparam int LONG_HOLD       = 80;
	localparam int SETTLE          = 8;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 122;
	// Indexes past the two gain registers; writes there must change nothing.
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		in_word_t tick;
		bit       known;
		result_t  want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;

	// Loop state as the block should hold it.
	int gain_p;
	int gain_i;
	int integ;
	int tune_ticks;
	int held_pct;
	bit square_hi;

	result_t pending_results[$];
	row_t    rows[$];
	int      mismatches = 0;
	int      quiet_cycles = 0;
	bit      idle_bursts;
	bit      long_hold_req;

	pi_current_loop_pwm i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int clamp_sym(int v, int lim);
		return (v > lim) ? lim : (v < -lim) ? -lim : v;
	endfunction

	// PI update with the integral clamp; the division truncates toward zero.
	function automatic int pi_drive(int ref_ma, int sensed);
		int     err;
		longint acc;
		longint u;
		err = ref_ma - sensed;
		integ = clamp_sym(integ + err, INTEG_MAX);
		acc = longint'(gain_p) * err + longint'(gain_i) * integ;
		u = acc / 256;
		if (u > PCT_MAX) begin
			u = PCT_MAX;
		end else if (u < -PCT_MAX) begin
			u = -PCT_MAX;
		end
		return int'(u);
	endfunction

	function automatic result_t loop_tick(in_word_t t);
		int      ref_ma;
		int      mag;
		bit      ran;
		result_t r;
		ref_ma = 0;
		ran = 1'b0;
		case (t.mode)
			MODE_IDLE: begin
				held_pct = 0;
				integ = 0;
			end
			MODE_PWM: begin
				held_pct = clamp_sym(int'($signed(t.manual_percent)), PCT_MAX);
			end
			MODE_TUNE: begin
				if (t.loop_enable) begin
					ref_ma = square_hi ? TUNE_HIGH_MA : 0;
					held_pct = pi_drive(ref_ma, int'($signed(t.sensed_ma)));
					ran = 1'b1;
					tune_ticks++;
					if (tune_ticks >= TUNE_HALF_TICKS) begin
						tune_ticks = 0;
						square_hi = !square_hi;
					end
				end else begin
					tune_ticks = 0;
					integ = 0;
				end
			end
			default: begin
				if (t.loop_enable) begin
					ref_ma = int'($signed(t.reference_ma));
					held_pct = pi_drive(ref_ma, int'($signed(t.sensed_ma)));
					ran = 1'b1;
				end else begin
					integ = 0;
				end
			end
		endcase
		mag = (held_pct < 0) ? -held_pct : held_pct;
		r.duty_count = 12'(mag * COUNTS_PER_PCT);
		r.direction = (held_pct >= 0);
		r.drive_percent = 8'(held_pct);
		r.reference_used = 12'(ref_ma);
		r.record_valid = ran && t.log_enable;
		return r;
	endfunction

	function automatic in_word_t rand_tick();
		in_word_t t;
		int       pick;
		int       center;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			t.mode = MODE_IDLE;
		end else if (pick < 20) begin
			t.mode = MODE_PWM;
		end else if (pick < 55) begin
			t.mode = MODE_TUNE;
		end else begin
			t.mode = MODE_TRACK;
		end
		t.loop_enable = ($urandom_range(0, 15) != 0);
		t.log_enable = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0) begin
			t.manual_percent = 8'($urandom);
		end else begin
			t.manual_percent = 8'(int'($urandom_range(0, 200)) - 100);
		end
		if ($urandom_range(0, 4) == 0) begin
			t.reference_ma = 12'($urandom);
		end else begin
			t.reference_ma = 12'(int'($urandom_range(0, 600)) - 300);
		end
		// Most samples sit near the reference so the drive is not always
		// saturated.
		if (t.mode == MODE_TUNE) begin
			center = 100;
		end else begin
			center = int'($signed(t.reference_ma));
		end
		if ($urandom_range(0, 4) == 0) begin
			t.sensed_ma = 13'($urandom);
		end else begin
			t.sensed_ma = 13'(center + int'($urandom_range(0, 240)) - 120);
		end
		return t;
	endfunction

	function automatic void add_row(mode_t m, int sensed, int ref_ma, int manual,
			bit en, bit log_on);
		row_t row;
		row.tick.mode = m;
		row.tick.sensed_ma = 13'(sensed);
		row.tick.reference_ma = 12'(ref_ma);
		row.tick.manual_percent = 8'(manual);
		row.tick.loop_enable = en;
		row.tick.log_enable = log_on;
		row.known = 1'b0;
		row.want = '0;
		rows.push_back(row);
	endfunction

	function automatic void add_known(mode_t m, int sensed, int ref_ma, int manual,
			bit en, bit log_on, int duty, bit dir, int drive, int ref_used, bit rec);
		add_row(m, sensed, ref_ma, manual, en, log_on);
		rows[$].known = 1'b1;
		rows[$].want.duty_count = 12'(duty);
		rows[$].want.direction = dir;
		rows[$].want.drive_percent = 8'(drive);
		rows[$].want.reference_used = 12'(ref_used);
		rows[$].want.record_valid = rec;
	endfunction

	// Leaves tvalid high so back-to-back words need no extra edge.
	task automatic push_tick(in_word_t t, bit known, result_t want);
		result_t pred;
		s_axis_tdata <= {3'b000, t.log_enable, t.loop_enable, t.manual_percent,
			t.reference_ma, t.sensed_ma, t.mode};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pred = loop_tick(t);
		pending_results.push_back(known ? want : pred);
	endtask

	task automatic sender_gap();
		int n;
		if (idle_bursts && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 18);
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain(int settle);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_PROP_GAIN) begin
			gain_p = int'($signed(val));
		end else if (idx == REG_INTEGRAL_GAIN) begin
			gain_i = int'($signed(val));
		end
	endtask

	task automatic set_gains(int p, int i, bit touch_spare);
		cfg_write(REG_PROP_GAIN, 16'(p));
		if (touch_spare) cfg_write(REG_SPARE_2, 16'($urandom));
		cfg_write(REG_INTEGRAL_GAIN, 16'(i));
		if (touch_spare) cfg_write(REG_SPARE_3, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic walk_rows();
		foreach (rows[k]) begin
			push_tick(rows[k].tick, rows[k].known, rows[k].want);
			sender_gap();
		end
		rows.delete();
		drain(SETTLE);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : result_sink
		int      hold;
		result_t got;
		result_t want;
		hold = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
				got.duty_count = m_axis_tdata[11:0];
				got.direction = m_axis_tdata[12];
				got.drive_percent = m_axis_tdata[20:13];
				got.reference_used = m_axis_tdata[32:21];
				got.record_valid = m_axis_tdata[33];
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result word with none expected: %h", m_axis_tdata);
					end
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display({"mismatch (exp/got): duty %0d/%0d dir %0d/%0d",
								" drive %0d/%0d ref %0d/%0d rec %0d/%0d"},
								want.duty_count, got.duty_count, want.direction, got.direction,
								want.drive_percent, got.drive_percent,
								want.reference_used, got.reference_used,
								want.record_valid, got.record_valid);
						end
					end
				end
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_req) begin
				// Long back-pressure fills the pipeline and must stall the input.
				long_hold_req = 1'b0;
				hold = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 17);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int phase_prop[PHASES];
		int phase_integ[PHASES];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PROP_GAIN;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		idle_bursts = 1'b1;
		long_hold_req = 1'b0;
		gain_p = 0;
		gain_i = 0;
		integ = 0;
		tune_ticks = 0;
		held_pct = 0;
		square_hi = 1'b0;
		phase_prop = '{256, 32767, -32768, 40, -300, 0, 1, 64};
		phase_integ = '{16, -32768, 32767, 3, -20, 0, 1, 8};
		phase_prop[5] = int'($signed(16'($urandom)));
		phase_integ[5] = int'($signed(16'($urandom)));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Gains are still zero here, so the loop drive stays at zero.
		add_known(MODE_IDLE, 0, 0, 0, 1, 1, 0, 1, 0, 0, 0);
		add_known(MODE_PWM, 0, 0, 100, 1, 1, 4000, 1, 100, 0, 0);
		add_known(MODE_PWM, 0, 0, -100, 0, 0, 4000, 0, -100, 0, 0);
		add_known(MODE_PWM, 0, 0, 127, 1, 1, 4000, 1, 100, 0, 0);
		add_known(MODE_PWM, 0, 0, -128, 1, 1, 4000, 0, -100, 0, 0);
		add_known(MODE_PWM, -4096, 2047, -1, 1, 1, 40, 0, -1, 0, 0);
		add_known(MODE_TRACK, 4095, -2048, 0, 0, 1, 40, 0, -1, 0, 0);
		add_known(MODE_TUNE, -4096, 2047, 0, 0, 1, 40, 0, -1, 0, 0);
		add_known(MODE_TRACK, -4096, 2047, 0, 1, 1, 0, 1, 0, 2047, 1);
		add_known(MODE_TRACK, 4095, -2048, 0, 1, 0, 0, 1, 0, -2048, 0);
		add_known(MODE_TUNE, 4095, 0, 0, 1, 1, 0, 1, 0, 0, 1);
		add_known(MODE_PWM, 0, 0, 1, 1, 0, 40, 1, 1, 0, 0);
		add_known(MODE_IDLE, 4095, 2047, 127, 1, 1, 0, 1, 0, 0, 0);
		walk_rows();

		set_gains(200, -7, 1'b0);
		add_row(MODE_TRACK, -4096, 2047, 0, 1, 1);
		add_row(MODE_TRACK, -4096, 2047, 0, 1, 0);
		add_row(MODE_TRACK, 4095, -2048, 0, 1, 1);
		add_row(MODE_TRACK, 4095, -2048, 0, 1, 1);
		add_row(MODE_TRACK, 10, 10, 0, 1, 1);
		add_row(MODE_TRACK, 1, 0, 0, 1, 1);
		add_row(MODE_TUNE, 150, 0, 0, 1, 1);
		add_row(MODE_TUNE, 150, 0, 0, 0, 1);
		add_row(MODE_TUNE, -20, 0, 0, 1, 0);
		add_row(MODE_IDLE, 0, 0, 0, 1, 1);
		add_row(MODE_PWM, 0, 0, 0, 1, 1);
		walk_rows();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_gains(phase_prop[ph], phase_integ[ph], ph == 2 || ph == 6);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				idle_bursts = (ph < PHASES - 1) && !(k >= 50 && k < 80);
				if (ph == 1 && k == 30) long_hold_req = 1'b1;
				if (ph == 3 && k == 60) drain(1);
				push_tick(rand_tick(), 1'b0, '0);
				sender_gap();
			end
			drain(SETTLE);
		end

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: pi_current_loop_pwm.f
rtl/pcl_pkg.sv
rtl/pcl_err_stage.sv
rtl/pcl_mac_stage.sv
rtl/pcl_drive_stage.sv
rtl/pi_current_loop_pwm.sv
dv/pi_current_loop_pwm_test.sv
